// ----- sv/wtcm_pkg.sv -----
// Package for the wall texture column mapper.
// Holds widths, codes, defaults and the command type shared by the front, queue and back.
// No dependencies.
package wtcm_pkg;

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEF       = 16;
    localparam int TEX_COORD_BITS_DEF  = 12;
    localparam int SCREEN_ROW_BITS_DEF = 12;

    // Fixed field widths of the channel payloads
    localparam int FACE_W      = 2;
    localparam int FRACTION_W  = 16;
    localparam int TEX_WIDTH_W = 13;
    localparam int HLOG_W      = 4;
    localparam int LINE_H_W    = 16;
    localparam int DRAW_W      = 12;
    localparam int COORD_W     = 12;
    localparam int SCREEN_H_W  = 13;

    // Internal arithmetic widths
    localparam int STEP_W = 32;
    localparam int POS_W  = 40;
    localparam int OFF_W  = 18;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register reset value
    localparam logic [SCREEN_H_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // Item opcodes
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Face codes
    localparam logic [FACE_W-1:0] FACE_NORTH = 2'd0;
    localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd1;

    // Classified item handed from front to back
    typedef struct packed {
        logic                      op;
        logic [FACE_W-1:0]         face;
        logic [COORD_W-1:0]        tex_x;
        logic [HLOG_W-1:0]         hlog;
        logic [LINE_H_W-1:0]       line_h;
        logic signed [OFF_W-1:0]   offset;
    } cmd_t;

endpackage

// ----- sv/wtcm_if.sv -----
// Channel interfaces of the wall texture column mapper: request items and texel results.
// Depends on wtcm_pkg for field widths.
interface wtcm_in_if
    import wtcm_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [FACE_W-1:0]      face;
    logic [FRACTION_W-1:0]  wall_fraction;
    logic                   hit_side;
    logic                   ray_x_negative;
    logic                   ray_y_positive;
    logic [TEX_WIDTH_W-1:0] tex_width;
    logic [HLOG_W-1:0]      tex_height_log2;
    logic [LINE_H_W-1:0]    line_height;
    logic [DRAW_W-1:0]      draw_start;

    modport source (
        output valid, opcode, face, wall_fraction, hit_side, ray_x_negative,
               ray_y_positive, tex_width, tex_height_log2, line_height, draw_start,
        input  ready
    );
    modport sink (
        input  valid, opcode, face, wall_fraction, hit_side, ray_x_negative,
               ray_y_positive, tex_width, tex_height_log2, line_height, draw_start,
        output ready
    );
endinterface

interface wtcm_out_if
    import wtcm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FACE_W-1:0]  face_out;
    logic [COORD_W-1:0] texel_x;
    logic [COORD_W-1:0] texel_y;

    modport source (
        output valid, face_out, texel_x, texel_y,
        input  ready
    );
    modport sink (
        input  valid, face_out, texel_x, texel_y,
        output ready
    );
endinterface

// ----- sv/wtcm_front.sv -----
// Front of the mapper: holds the screen height register, accepts items and
// classifies them into commands (texture column, mirroring, clamps, start offset).
// Depends on wtcm_pkg and wtcm_in_if.
module wtcm_front
    import wtcm_pkg::*;
#(
    parameter int TEX_COORD_BITS  = TEX_COORD_BITS_DEF,
    parameter int SCREEN_ROW_BITS = SCREEN_ROW_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    wtcm_in_if.sink               in_ch,
    input  logic                  cfg_wr_en,
    input  logic [SCREEN_H_W-1:0] cfg_wr_data,
    output logic                  cmd_valid,
    output cmd_t                  cmd_data,
    input  logic                  cmd_ready
);

    localparam logic [TEX_WIDTH_W-1:0] TEX_W_MAX = TEX_WIDTH_W'(1 << TEX_COORD_BITS);
    localparam logic [HLOG_W-1:0]      HLOG_MAX  = HLOG_W'(TEX_COORD_BITS);
    localparam logic [SCREEN_H_W-1:0]  DS_MASK   = SCREEN_H_W'((1 << SCREEN_ROW_BITS) - 1);
    localparam logic [SCREEN_H_W:0]    SH_MASK   =
        (SCREEN_H_W + 1)'((1 << (SCREEN_ROW_BITS + 1)) - 1);

    logic [SCREEN_H_W-1:0]              screen_height_reg;
    logic                               valid_reg;
    cmd_t                               cmd_reg;
    cmd_t                               cmd_next;
    logic                               in_fire;

    logic [TEX_WIDTH_W-1:0]             width_fix;
    logic [FRACTION_W+TEX_WIDTH_W-1:0]  col_prod;
    logic [TEX_WIDTH_W-1:0]             col_raw;
    logic [TEX_WIDTH_W-1:0]             col_fin;
    logic                               mirror;
    logic [LINE_H_W-1:0]                lh_fix;
    logic [SCREEN_H_W-1:0]              ds_m;
    logic [SCREEN_H_W:0]                sh_m;
    logic [SCREEN_H_W-1:0]              sh_half;
    logic [LINE_H_W-2:0]                lh_half;

    assign in_ch.ready = !valid_reg || cmd_ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign cmd_valid   = valid_reg;
    assign cmd_data    = cmd_reg;

    // Clamp the texture width, map the hit fraction to a column and mirror it
    always_comb
    begin
        if (in_ch.tex_width == '0)
            width_fix = TEX_WIDTH_W'(1);
        else if (in_ch.tex_width > TEX_W_MAX)
            width_fix = TEX_W_MAX;
        else
            width_fix = in_ch.tex_width;
        col_prod = (FRACTION_W + TEX_WIDTH_W)'(in_ch.wall_fraction) *
                   (FRACTION_W + TEX_WIDTH_W)'(width_fix);
        col_raw  = col_prod[FRACTION_W +: TEX_WIDTH_W];
        if (in_ch.face == FACE_NORTH || in_ch.face == FACE_SOUTH)
            mirror = in_ch.hit_side && in_ch.ray_y_positive;
        else
            mirror = !in_ch.hit_side && in_ch.ray_x_negative;
        col_fin = mirror ? (width_fix - col_raw - TEX_WIDTH_W'(1)) : col_raw;
    end

    // Build the classified command, start offset included
    always_comb
    begin
        lh_fix  = (in_ch.line_height == '0) ? LINE_H_W'(1) : in_ch.line_height;
        ds_m    = SCREEN_H_W'(in_ch.draw_start) & DS_MASK;
        sh_m    = (SCREEN_H_W + 1)'(screen_height_reg) & SH_MASK;
        sh_half = sh_m[SCREEN_H_W:1];
        lh_half = in_ch.line_height[LINE_H_W-1:1];

        cmd_next.op     = in_ch.opcode;
        cmd_next.face   = in_ch.face;
        cmd_next.tex_x  = COORD_W'(col_fin);
        cmd_next.hlog   = (in_ch.tex_height_log2 > HLOG_MAX) ? HLOG_MAX : in_ch.tex_height_log2;
        cmd_next.line_h = lh_fix;
        cmd_next.offset = $signed(OFF_W'(ds_m)) - $signed(OFF_W'(sh_half))
                        + $signed(OFF_W'(lh_half));
    end

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            screen_height_reg <= SCREEN_HEIGHT_RST;
        else if (cfg_wr_en)
            screen_height_reg <= cfg_wr_data;
    end

    // Track the staged item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ch.ready)
            valid_reg <= in_ch.valid;
    end

    // Load the staged payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            cmd_reg <= cmd_next;
    end

endmodule

// ----- sv/wtcm_queue.sv -----
// Short command queue between the front and the back of the mapper.
// Depends on wtcm_pkg for cmd_t and the queue depth.
module wtcm_queue
    import wtcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_data,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_data,
    input  logic pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/wtcm_back.sv -----
// Back of the mapper: holds the column state, runs the per-column step divide and
// start-position multiply, and emits one texel coordinate per item.
// Depends on wtcm_pkg and wtcm_out_if.
module wtcm_back
    import wtcm_pkg::*;
#(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int TEX_COORD_BITS = TEX_COORD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd_data,
    output logic      cmd_ready,
    wtcm_out_if.source out_ch
);

    // Dividend bits: texture height shifted up by the fraction
    localparam int QW    = TEX_COORD_BITS + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(QW);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_EMIT = 4'b1000
    } back_state_t;

    back_state_t                 state_reg, state_next;

    logic [FACE_W-1:0]           face_reg;
    logic [TEX_COORD_BITS-1:0]   tex_x_reg;
    logic [TEX_COORD_BITS-1:0]   mask_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [POS_W-1:0]            pos_reg;

    logic [QW-1:0]               dq_reg;
    logic [LINE_H_W-1:0]         rem_reg;
    logic [LINE_H_W-1:0]         lh_reg;
    logic signed [OFF_W-1:0]     off_reg;
    logic [CNT_W-1:0]            cnt_reg;

    logic                        out_valid_reg;
    logic [FACE_W-1:0]           out_face_reg;
    logic [COORD_W-1:0]          out_tx_reg;
    logic [COORD_W-1:0]          out_ty_reg;

    logic                        out_free;
    logic                        emit;
    logic                        start;
    logic [TEX_COORD_BITS:0]     th;
    logic [TEX_COORD_BITS-1:0]   mask_next;
    logic [LINE_H_W:0]           rem_sh;
    logic                        q_bit;
    logic [63:0]                 q_ext;
    logic [STEP_W-1:0]           step_sat;
    logic signed [OFF_W+STEP_W:0] prod;
    logic [TEX_COORD_BITS-1:0]   row;

    assign out_free = !out_valid_reg || out_ch.ready;

    // Decode what the back does this cycle
    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        start      = 1'b0;
        cmd_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_data.op == OP_BEGIN)
                    begin
                        start      = 1'b1;
                        cmd_ready  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else if (out_free)
                    begin
                        emit      = 1'b1;
                        cmd_ready = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(QW - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Form the height mask, one divide step, step saturation, start position and texel row
    always_comb
    begin
        th        = (TEX_COORD_BITS + 1)'(1) << cmd_data.hlog;
        mask_next = TEX_COORD_BITS'(th - (TEX_COORD_BITS + 1)'(1));
        rem_sh    = {rem_reg, dq_reg[QW-1]};
        q_bit     = (rem_sh >= {1'b0, lh_reg});
        q_ext     = 64'(dq_reg);
        step_sat  = (|q_ext[63:STEP_W]) ? '1 : q_ext[STEP_W-1:0];
        prod      = off_reg * $signed({1'b0, step_sat});
        row       = pos_reg[FRAC_BITS +: TEX_COORD_BITS] & mask_reg;
    end

    // Advance the sequencer and the column state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            face_reg  <= '0;
            tex_x_reg <= '0;
            mask_reg  <= '0;
            step_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                face_reg  <= cmd_data.face;
                tex_x_reg <= cmd_data.tex_x[TEX_COORD_BITS-1:0];
                mask_reg  <= mask_next;
            end
            if (state_reg == ST_MUL)
            begin
                step_reg <= step_sat;
                pos_reg  <= prod[POS_W-1:0];
            end
            else if (emit)
            begin
                pos_reg <= pos_reg + POS_W'(step_reg);
            end
        end
    end

    // Run the restoring divider, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= QW'(1) << (cmd_data.hlog + FRAC_BITS);
            rem_reg <= '0;
            cnt_reg <= '0;
            lh_reg  <= cmd_data.line_h;
            off_reg <= cmd_data.offset;
        end
        else if (state_reg == ST_DIV)
        begin
            dq_reg  <= {dq_reg[QW-2:0], q_bit};
            rem_reg <= q_bit ? LINE_H_W'(rem_sh - {1'b0, lh_reg}) : LINE_H_W'(rem_sh);
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_face_reg <= face_reg;
            out_tx_reg   <= COORD_W'(tex_x_reg);
            out_ty_reg   <= COORD_W'(row);
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.face_out = out_face_reg;
    assign out_ch.texel_x  = out_tx_reg;
    assign out_ch.texel_y  = out_ty_reg;

endmodule

// ----- sv/wall_texture_column_mapper_top.sv -----
// Wall texture column mapper, top level: front, command queue, back.
// Next-row items: one per cycle sustained while the output is not stalled; each passes the
// front's command register and the queue before it reaches the result register.
// Begin items: the back runs the step divide (one quotient bit per cycle), the start multiply
// and the result hand-off, and takes the next command only in the cycle after the hand-off.
// Reset (rst_n, async, active low) clears column state and queue; screen height = 480.
module wall_texture_column_mapper_top
    import wtcm_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int TEX_COORD_BITS  = TEX_COORD_BITS_DEF,
    parameter int SCREEN_ROW_BITS = SCREEN_ROW_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    wtcm_in_if.sink               in_ch,
    wtcm_out_if.source            out_ch,
    input  logic                  cfg_wr_en,
    input  logic [SCREEN_H_W-1:0] cfg_wr_data
);

    logic push_valid;
    cmd_t push_data;
    logic push_ready;
    logic pop_valid;
    cmd_t pop_data;
    logic pop_ready;

    // Accept and classify items
    wtcm_front #(
        .TEX_COORD_BITS  (TEX_COORD_BITS),
        .SCREEN_ROW_BITS (SCREEN_ROW_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (push_valid),
        .cmd_data    (push_data),
        .cmd_ready   (push_ready)
    );

    // Decouple front and back
    wtcm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // Carry out commands and emit results
    wtcm_back #(
        .FRAC_BITS      (FRAC_BITS),
        .TEX_COORD_BITS (TEX_COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_data  (pop_data),
        .cmd_ready (pop_ready),
        .out_ch    (out_ch)
    );

endmodule
